FILE: rtl/ssdw_pkg.sv
// Shared types, constants and the segment lookup for the two-wire display writer.
// Used by ssdw_seg_encode, ssdw_sequencer and the top level; depends on nothing.
package ssdw_pkg;

    // Number of digit fields carried in one input transaction.
    localparam int INPUT_DIGITS      = 4;
    localparam int DIGIT_W           = 5;
    localparam int DIGIT_COUNT_DEF   = 4;
    localparam int BRIGHT_W          = 3;
    localparam logic [2:0] BRIGHT_RESET = 3'd2;

    // Command bytes of the three framed transactions.
    localparam logic [7:0] CMD_DATA  = 8'h40;
    localparam logic [7:0] CMD_ADDR  = 8'hC0;
    localparam logic [7:0] CMD_DISP  = 8'h88;
    localparam logic [7:0] DOT_MASK  = 8'h80;
    localparam logic [7:0] SEG_BLANK = 8'h00;

    // Request kinds carried in tuser.
    localparam logic REQ_SHOW = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Pin sequencer steps.
    typedef enum logic [4:0] {
        ST_IDLE        = 5'd0,
        ST_START_DIO   = 5'd1,
        ST_START_CLK   = 5'd2,
        ST_BIT_CLK_LO  = 5'd3,
        ST_BIT_DATA    = 5'd4,
        ST_BIT_CLK_HI  = 5'd5,
        ST_ACK_CLK_LO  = 5'd6,
        ST_ACK_DIO_HI  = 5'd7,
        ST_ACK_CLK_HI  = 5'd8,
        ST_RELEASE     = 5'd9,
        ST_POLL        = 5'd10,
        ST_WAIT        = 5'd11,
        ST_PULSE_END   = 5'd12,
        ST_STOP_CLK_LO = 5'd13,
        ST_STOP_DIO_LO = 5'd14,
        ST_STOP_CLK_HI = 5'd15,
        ST_STOP_DIO_HI = 5'd16
    } step_t;

    // One registered input transaction.
    typedef struct packed {
        logic                                  req_type;
        logic [INPUT_DIGITS-1:0][DIGIT_W-1:0]  digits;
        logic                                  show_dots;
        logic                                  dio_sample;
    } item_t;

    // Pin state and status after one transaction.
    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic dio_drive;
        logic busy_res;
        logic done_res;
    } pins_t;

    // Seven-segment pattern of a hex digit; codes above 15 are blank.
    function automatic logic [7:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [7:0] s;
        case (d)
            5'd0:    s = 8'h3f;
            5'd1:    s = 8'h06;
            5'd2:    s = 8'h5b;
            5'd3:    s = 8'h4f;
            5'd4:    s = 8'h66;
            5'd5:    s = 8'h6d;
            5'd6:    s = 8'h7d;
            5'd7:    s = 8'h07;
            5'd8:    s = 8'h7f;
            5'd9:    s = 8'h6f;
            5'd10:   s = 8'h77;
            5'd11:   s = 8'h7c;
            5'd12:   s = 8'h39;
            5'd13:   s = 8'h5e;
            5'd14:   s = 8'h79;
            5'd15:   s = 8'h71;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/ssdw_seg_encode.sv
// Turns the hex digits and dot flag of a show request into segment bytes.
// Depends on ssdw_pkg for the lookup function and field widths.
module ssdw_seg_encode #(
    parameter int DIGIT_COUNT = ssdw_pkg::DIGIT_COUNT_DEF
) (
    input  logic [ssdw_pkg::INPUT_DIGITS-1:0][ssdw_pkg::DIGIT_W-1:0] digits,
    input  logic                                                   show_dots,
    output logic [DIGIT_COUNT-1:0][7:0]                            segments
);
    import ssdw_pkg::*;

    // Each position looks up its own digit; positions past the input fields are blank.
    always_comb
    begin
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (i < INPUT_DIGITS)
                segments[i] = seg_of(digits[(i < INPUT_DIGITS) ? i : 0]);
            else
                segments[i] = SEG_BLANK;
            if (i == 1 && show_dots)
                segments[i] = segments[i] | DOT_MASK;
        end
    end

endmodule

FILE: rtl/ssdw_sequencer.sv
// Pin sequencer: holds the waveform state and the latched segment bytes and
// works out the pin levels after each transaction. Depends on ssdw_pkg.
module ssdw_sequencer #(
    parameter int DIGIT_COUNT = ssdw_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step_en,
    input  ssdw_pkg::item_t                     item,
    input  logic [DIGIT_COUNT-1:0][7:0]         segments,
    input  logic [ssdw_pkg::BRIGHT_W-1:0]       brightness,
    output ssdw_pkg::pins_t                     pins
);
    import ssdw_pkg::*;

    localparam int SEL_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [3:0] LAST_SEG_IDX = 4'(DIGIT_COUNT + 1);
    localparam logic [3:0] BRIGHT_IDX   = 4'(DIGIT_COUNT + 2);

    step_t       step_reg, step_next;
    logic [3:0]  frame_reg, frame_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  count_reg, count_next;
    logic        clk_reg, clk_next;
    logic        dio_reg, dio_next;
    logic        drive_reg, drive_next;
    logic        busy_reg, busy_next;
    logic        seg_we;
    logic        done;
    logic [DIGIT_COUNT-1:0][7:0] seg_reg;

    logic [3:0]       frame_inc;
    logic [SEL_W-1:0] seg_sel;
    logic [7:0]       byte_next;
    logic [2:0]       count_inc;
    logic             ack_to_stop;

    // Byte that follows the current frame.
    always_comb
    begin
        frame_inc = frame_reg + 4'd1;
        seg_sel   = SEL_W'(frame_inc - 4'd2);
        if (frame_inc == 4'd0)
            byte_next = CMD_DATA;
        else if (frame_inc == 4'd1)
            byte_next = CMD_ADDR;
        else if (frame_inc <= LAST_SEG_IDX)
            byte_next = seg_reg[seg_sel];
        else
            byte_next = CMD_DISP | {5'd0, brightness};
        count_inc   = count_reg + 3'd1;
        ack_to_stop = (frame_reg == 4'd0) || (frame_reg >= LAST_SEG_IDX);
    end

    // Next state and pin levels.
    always_comb
    begin
        step_next  = step_reg;
        frame_next = frame_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        clk_next   = clk_reg;
        dio_next   = dio_reg;
        drive_next = drive_reg;
        busy_next  = busy_reg;
        seg_we     = 1'b0;
        done       = 1'b0;
        if (step_en)
        begin
            if (item.req_type == REQ_SHOW)
            begin
                if (!busy_reg)
                begin
                    seg_we     = 1'b1;
                    frame_next = 4'd0;
                    shift_next = CMD_DATA;
                    count_next = 3'd0;
                    step_next  = ST_START_DIO;
                    busy_next  = 1'b1;
                end
            end
            else
            begin
                case (step_reg)
                    ST_IDLE: ;
                    ST_START_DIO:
                    begin
                        dio_next  = 1'b0;
                        step_next = ST_START_CLK;
                    end
                    ST_START_CLK:
                    begin
                        clk_next  = 1'b0;
                        step_next = ST_BIT_CLK_LO;
                    end
                    ST_BIT_CLK_LO:
                    begin
                        clk_next  = 1'b0;
                        step_next = ST_BIT_DATA;
                    end
                    ST_BIT_DATA:
                    begin
                        dio_next  = shift_reg[0];
                        step_next = ST_BIT_CLK_HI;
                    end
                    ST_BIT_CLK_HI:
                    begin
                        clk_next   = 1'b1;
                        shift_next = {1'b0, shift_reg[7:1]};
                        count_next = count_inc;
                        step_next  = (count_inc == 3'd0) ? ST_ACK_CLK_LO : ST_BIT_CLK_LO;
                    end
                    ST_ACK_CLK_LO:
                    begin
                        clk_next  = 1'b0;
                        step_next = ST_ACK_DIO_HI;
                    end
                    ST_ACK_DIO_HI:
                    begin
                        dio_next  = 1'b1;
                        step_next = ST_ACK_CLK_HI;
                    end
                    ST_ACK_CLK_HI:
                    begin
                        clk_next  = 1'b1;
                        step_next = ST_RELEASE;
                    end
                    ST_RELEASE:
                    begin
                        drive_next = 1'b0;
                        step_next  = ST_POLL;
                    end
                    ST_POLL, ST_WAIT:
                    begin
                        if (item.dio_sample && step_reg == ST_POLL)
                            step_next = ST_WAIT;
                        else if (item.dio_sample)
                        begin
                            // Line still high: drive a one-tick low pulse.
                            drive_next = 1'b1;
                            dio_next   = 1'b0;
                            step_next  = ST_PULSE_END;
                        end
                        else
                        begin
                            // Acknowledge seen: drive again and move on.
                            drive_next = 1'b1;
                            if (ack_to_stop)
                                step_next = ST_STOP_CLK_LO;
                            else
                            begin
                                frame_next = frame_inc;
                                shift_next = byte_next;
                                count_next = 3'd0;
                                step_next  = ST_BIT_CLK_LO;
                            end
                        end
                    end
                    ST_PULSE_END:
                    begin
                        drive_next = 1'b0;
                        step_next  = ST_POLL;
                    end
                    ST_STOP_CLK_LO:
                    begin
                        clk_next  = 1'b0;
                        step_next = ST_STOP_DIO_LO;
                    end
                    ST_STOP_DIO_LO:
                    begin
                        dio_next  = 1'b0;
                        step_next = ST_STOP_CLK_HI;
                    end
                    ST_STOP_CLK_HI:
                    begin
                        clk_next  = 1'b1;
                        step_next = ST_STOP_DIO_HI;
                    end
                    ST_STOP_DIO_HI:
                    begin
                        dio_next = 1'b1;
                        if (frame_reg >= BRIGHT_IDX)
                        begin
                            step_next = ST_IDLE;
                            busy_next = 1'b0;
                            done      = 1'b1;
                        end
                        else
                        begin
                            frame_next = frame_inc;
                            shift_next = byte_next;
                            count_next = 3'd0;
                            step_next  = ST_START_DIO;
                        end
                    end
                    default:
                    begin
                        step_next = ST_IDLE;
                        busy_next = 1'b0;
                    end
                endcase
            end
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            frame_reg <= 4'd0;
            shift_reg <= 8'd0;
            count_reg <= 3'd0;
            clk_reg   <= 1'b1;
            dio_reg   <= 1'b1;
            drive_reg <= 1'b1;
            busy_reg  <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            frame_reg <= frame_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            clk_reg   <= clk_next;
            dio_reg   <= dio_next;
            drive_reg <= drive_next;
            busy_reg  <= busy_next;
        end
    end

    // Latched segment bytes, written on an accepted show request.
    always_ff @(posedge clk)
    begin
        if (seg_we)
            seg_reg <= segments;
    end

    assign pins.clk_level = clk_next;
    assign pins.dio_level = dio_next;
    assign pins.dio_drive = drive_next;
    assign pins.busy_res  = busy_next;
    assign pins.done_res  = done;

    // The sequencer is busy exactly when it is away from idle.
    a_busy_matches_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (step_reg != ST_IDLE))
        else $error("busy flag disagrees with sequencer step");

    // The data line is released only while polling for the acknowledge.
    a_release_only_poll: assert property (@(posedge clk) disable iff (!rst_n)
        !drive_reg |-> (step_reg == ST_POLL || step_reg == ST_WAIT))
        else $error("data line released outside the acknowledge poll");

    // A completed sequence leaves the sequencer idle.
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (step_reg == ST_IDLE && !busy_reg))
        else $error("sequencer not idle after done");

endmodule

FILE: rtl/seven_segment_two_wire_display_writer.sv
// Two-wire segment display writer. A result is offered once its input transaction has
// passed the input register and then the result register; it is held there until taken.
// Throughput: one transaction per cycle when m_tready does not stall; the single-step pin
// sequencer sets this. While a result waits on m_tready, the empty input register can
// still take one new transaction. Reset (rst_n, asynchronous, active low): sequencer
// idle, lines high and driven, brightness 2. Depends on ssdw_pkg and submodules.
module seven_segment_two_wire_display_writer #(
    parameter int DIGIT_COUNT = ssdw_pkg::DIGIT_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // digit_zero[4:0], digit_one[9:5], digit_two[14:10], digit_three[19:15],
    // show_dots[20], dio_sample[21], zero pad[23:22]
    input  logic [23:0]                    s_tdata,
    // req_type[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // clk_level[0], dio_level[1], dio_drive[2], busy_res[3], done_res[4], zero pad[7:5]
    output logic [7:0]                     m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ssdw_pkg::BRIGHT_W-1:0]  cfg_data
);
    import ssdw_pkg::*;

    logic                        in_valid_reg, in_valid_next;
    item_t                       item_reg;
    logic                        out_valid_reg, out_valid_next;
    pins_t                       out_reg;
    logic [BRIGHT_W-1:0]         bright_reg;
    logic                        accept;
    logic                        advance;
    logic [DIGIT_COUNT-1:0][7:0] segments;
    pins_t                       pins;

    // Handshake: the registered item moves on when the result register is free.
    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || m_tready);
        s_tready       = !in_valid_reg || advance;
        accept         = s_tvalid && s_tready;
        in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Valid flags and the brightness register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            bright_reg    <= BRIGHT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                bright_reg <= cfg_data;
        end
    end

    // Payload registers on both sides.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.req_type   <= s_tuser;
            item_reg.digits[0]  <= s_tdata[4:0];
            item_reg.digits[1]  <= s_tdata[9:5];
            item_reg.digits[2]  <= s_tdata[14:10];
            item_reg.digits[3]  <= s_tdata[19:15];
            item_reg.show_dots  <= s_tdata[20];
            item_reg.dio_sample <= s_tdata[21];
        end
        if (advance)
            out_reg <= pins;
    end

    ssdw_seg_encode #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_seg_encode (
        .digits    (item_reg.digits),
        .show_dots (item_reg.show_dots),
        .segments  (segments)
    );

    ssdw_sequencer #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_sequencer (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .item       (item_reg),
        .segments   (segments),
        .brightness (bright_reg),
        .pins       (pins)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_reg.done_res, out_reg.busy_res, out_reg.dio_drive,
                        out_reg.dio_level, out_reg.clk_level};

    // Input side stalls only behind a held item and a waiting, untaken result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // A done result never reports a sequence still in progress.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.done_res) |-> !out_reg.busy_res)
        else $error("done reported while busy");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the two-wire segment display writer: show requests and
// line ticks go in, pin states come out and are checked against a cycle-free predictor.
// Depends on ssdw_pkg and seven_segment_two_wire_display_writer.
module testbench;

    import ssdw_pkg::*;

    localparam int NDIG           = DIGIT_COUNT_DEF;
    localparam int PHASE_ITEMS    = 95;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // Segment patterns of hex digits 0..15, digit 0 in the lowest byte.
    localparam logic [127:0] GLYPHS = {
        8'h71, 8'h79, 8'h5e, 8'h39, 8'h7c, 8'h77, 8'h6f, 8'h7f,
        8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
    };

    // Predicts the pin waveform and compares it with what the block sends back.
    class display_scoreboard;
        logic [2:0] brightness;
        step_t      step;
        logic [3:0] frame;
        logic [7:0] shift_byte;
        logic [2:0] bits_sent;
        logic [7:0] seg_bytes [NDIG];
        logic       clk_pin;
        logic       dio_pin;
        logic       drive_pin;
        logic       busy;
        pins_t      expected_q [$];
        int         errors;
        int         shows_taken;
        int         ticks_applied;
        int         updates;
        int         results;

        function new();
            brightness    = BRIGHT_RESET;
            step          = ST_IDLE;
            frame         = '0;
            shift_byte    = '0;
            bits_sent     = '0;
            clk_pin       = 1'b1;
            dio_pin       = 1'b1;
            drive_pin     = 1'b1;
            busy          = 1'b0;
            errors        = 0;
            shows_taken   = 0;
            ticks_applied = 0;
            updates       = 0;
            results       = 0;
            foreach (seg_bytes[i])
                seg_bytes[i] = SEG_BLANK;
        endfunction

        // Byte sent in a given slot of the whole update.
        function logic [7:0] frame_byte(logic [3:0] idx);
            if (idx == 0)
                return CMD_DATA;
            if (idx == 1)
                return CMD_ADDR;
            if (idx <= NDIG + 1)
                return seg_bytes[(idx - 2) % NDIG];
            return CMD_DISP | {5'd0, brightness};
        endfunction

        function void next_frame(step_t nxt);
            frame      = frame + 4'd1;
            shift_byte = frame_byte(frame);
            bits_sent  = '0;
            step       = nxt;
        endfunction

        // The acknowledge is over: stop after single-byte frames and after the last
        // segment byte, otherwise go on with the next byte of the same frame.
        function void finish_ack();
            drive_pin = 1'b1;
            if (frame == 0 || frame >= NDIG + 1)
                step = ST_STOP_CLK_LO;
            else
                next_frame(ST_BIT_CLK_LO);
        endfunction

        // Advances the predictor by one accepted input transaction.
        function void note_input(logic req, logic [3:0][4:0] digits, logic dots,
                                 logic sample);
            pins_t      e;
            logic       done;
            logic [7:0] pattern;
            done = 1'b0;
            if (req == REQ_SHOW) begin
                // A show while a sequence runs is dropped.
                if (!busy) begin
                    for (int i = 0; i < NDIG; i++) begin
                        pattern = SEG_BLANK;
                        if (i < 4 && digits[i] < 16)
                            pattern = GLYPHS[digits[i] * 8 +: 8];
                        if (i == 1 && dots)
                            pattern = pattern | DOT_MASK;
                        seg_bytes[i] = pattern;
                    end
                    frame      = '0;
                    shift_byte = frame_byte(4'd0);
                    bits_sent  = '0;
                    step       = ST_START_DIO;
                    busy       = 1'b1;
                    shows_taken++;
                end
            end else begin
                if (busy)
                    ticks_applied++;
                case (step)
                    ST_IDLE: ;
                    ST_START_DIO: begin dio_pin = 1'b0; step = ST_START_CLK; end
                    ST_START_CLK: begin clk_pin = 1'b0; step = ST_BIT_CLK_LO; end
                    ST_BIT_CLK_LO: begin clk_pin = 1'b0; step = ST_BIT_DATA; end
                    ST_BIT_DATA: begin dio_pin = shift_byte[0]; step = ST_BIT_CLK_HI; end
                    ST_BIT_CLK_HI: begin
                        clk_pin    = 1'b1;
                        shift_byte = shift_byte >> 1;
                        bits_sent  = bits_sent + 3'd1;
                        step       = (bits_sent == 0) ? ST_ACK_CLK_LO : ST_BIT_CLK_LO;
                    end
                    ST_ACK_CLK_LO: begin clk_pin = 1'b0; step = ST_ACK_DIO_HI; end
                    ST_ACK_DIO_HI: begin dio_pin = 1'b1; step = ST_ACK_CLK_HI; end
                    ST_ACK_CLK_HI: begin clk_pin = 1'b1; step = ST_RELEASE; end
                    ST_RELEASE: begin drive_pin = 1'b0; step = ST_POLL; end
                    ST_POLL: begin
                        if (sample)
                            step = ST_WAIT;
                        else
                            finish_ack();
                    end
                    ST_WAIT: begin
                        // Line still high: pull it low for one tick and poll again.
                        if (sample) begin
                            drive_pin = 1'b1;
                            dio_pin   = 1'b0;
                            step      = ST_PULSE_END;
                        end else begin
                            finish_ack();
                        end
                    end
                    ST_PULSE_END: begin drive_pin = 1'b0; step = ST_POLL; end
                    ST_STOP_CLK_LO: begin clk_pin = 1'b0; step = ST_STOP_DIO_LO; end
                    ST_STOP_DIO_LO: begin dio_pin = 1'b0; step = ST_STOP_CLK_HI; end
                    ST_STOP_CLK_HI: begin clk_pin = 1'b1; step = ST_STOP_DIO_HI; end
                    ST_STOP_DIO_HI: begin
                        dio_pin = 1'b1;
                        if (frame >= NDIG + 2) begin
                            step = ST_IDLE;
                            busy = 1'b0;
                            done = 1'b1;
                            updates++;
                        end else begin
                            next_frame(ST_START_DIO);
                        end
                    end
                    default: begin step = ST_IDLE; busy = 1'b0; end
                endcase
            end
            e.clk_level = clk_pin;
            e.dio_level = dio_pin;
            e.dio_drive = drive_pin;
            e.busy_res  = busy;
            e.done_res  = done;
            expected_q.push_back(e);
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(logic [7:0] data);
            pins_t e;
            results++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("result %0d arrived with nothing expected: %b", results,
                             data[4:0]);
                return;
            end
            e = expected_q.pop_front();
            if (data[0] !== e.clk_level || data[1] !== e.dio_level ||
                data[2] !== e.dio_drive || data[3] !== e.busy_res ||
                data[4] !== e.done_res) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("result %0d: expected clk %b dio %b drive %b busy %b done %b",
                             results, e.clk_level, e.dio_level, e.dio_drive, e.busy_res,
                             e.done_res);
                    $display("    got clk %b dio %b drive %b busy %b done %b",
                             data[0], data[1], data[2], data[3], data[4]);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;
    logic        hold_off = 1'b0;
    int          send_idle_pct;
    int          stall_pct;
    int          quiet_cycles;
    display_scoreboard sb;

    seven_segment_two_wire_display_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver side: random stalls, or a long hold-off while one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready = 1'b0;
        else
            m_tready = !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Every accepted transaction on either stream goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata[19:0], s_tdata[20], s_tdata[21]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("no transaction for %0d cycles, giving up", WATCHDOG_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one input transaction, with random idle cycles first; returns at the
    // falling edge after it was taken.
    task automatic send_item(input logic req, input logic [19:0] digits,
                             input logic dots, input logic sample);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tuser  = req;
        s_tdata  = {2'b00, sample, dots, digits};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Writes the brightness register once the block has drained.
    task automatic write_brightness(input logic [2:0] level);
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        cfg_data  = level;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.brightness = level;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly blanks and hex digits, sometimes any 5-bit code.
    function automatic logic [4:0] pick_digit();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return 5'd16;
        if (r < 8)
            return 5'($urandom_range(15));
        return 5'($urandom_range(31));
    endfunction

    function automatic logic [19:0] pick_digits();
        if ($urandom_range(5) == 0)
            return {4{5'd16}};
        return {pick_digit(), pick_digit(), pick_digit(), pick_digit()};
    endfunction

    // Display updates with random acknowledge behavior, plus stray requests; a running
    // update carries on into the next phase.
    task automatic run_phase();
        int counted;
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            if (!sb.busy) begin
                if ($urandom_range(99) < 15)
                    send_item(REQ_TICK, 20'($urandom), $urandom_range(1), $urandom_range(1));
                else
                    send_item(REQ_SHOW, pick_digits(), $urandom_range(1), $urandom_range(1));
            end else if ($urandom_range(99) < 4) begin
                send_item(REQ_SHOW, pick_digits(), $urandom_range(1), $urandom_range(1));
            end else begin
                send_item(REQ_TICK, 20'($urandom), $urandom_range(1),
                          $urandom_range(99) < 30);
            end
            counted++;
        end
    endtask

    initial
    begin
        sb            = new();
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = REQ_TICK;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        quiet_cycles  = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Long receiver hold-off early in the first phase, so the block backs up.
        fork
            begin
                repeat (40) @(posedge clk);
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none

        // Directed: ticks while idle, a show with extreme digits and dots, a show that
        // is dropped because a sequence runs, then the start of the waveform.
        send_item(REQ_TICK, '0, 1'b0, 1'b0);
        send_item(REQ_TICK, '1, 1'b1, 1'b1);
        send_item(REQ_SHOW, {5'd31, 5'd16, 5'd15, 5'd0}, 1'b1, 1'b0);
        send_item(REQ_SHOW, {4{5'd8}}, 1'b0, 1'b1);
        for (int i = 0; i < 18; i++)
            send_item(REQ_TICK, '0, 1'b0, i[0]);

        // Phase with no idling at reset brightness, then three idling patterns.
        run_phase();
        send_idle_pct = 82;
        stall_pct     = 0;
        write_brightness(3'd0);
        run_phase();
        send_idle_pct = 0;
        stall_pct     = 82;
        write_brightness(3'd7);
        run_phase();
        send_idle_pct = 18;
        stall_pct     = 18;
        write_brightness(3'($urandom_range(7)));
        run_phase();

        // Drain what is still expected, then allow for the pipeline latency.
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.expected_q.size() != 0) begin
            $display("%0d results never arrived", sb.expected_q.size());
            sb.errors += sb.expected_q.size();
        end

        $display("covered %0d latched show requests, %0d sequencer ticks, %0d full updates",
                 sb.shows_taken, sb.ticks_applied, sb.updates);
        $display("checked %0d results over four handshake patterns, %0d failures",
                 sb.results, sb.errors);
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ssdw_pkg.sv
rtl/ssdw_seg_encode.sv
rtl/ssdw_sequencer.sv
rtl/seven_segment_two_wire_display_writer.sv
test/testbench.sv
